>>> sv/huffman_stream_decoder_assert.svh
// Assertion macros shared by the Huffman stream decoder modules.
`ifndef HUFFMAN_STREAM_DECODER_ASSERT_SVH
`define HUFFMAN_STREAM_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HSD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsd property violated");
`define HSD_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hsd forbidden condition");
`else
`define HSD_ASSERT(lbl, prop)
`define HSD_NEVER(lbl, cond)
`endif
`endif

>>> sv/hsd_pkg.sv
// Shared constants and types of the Huffman stream decoder.
`default_nettype none
package hsd_pkg;
    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = 8;
    localparam int MAX_CODE_BITS = 31;
    localparam int LEN_W         = 5;
    localparam int COUNT_W       = 9;
    localparam int TOTAL_W       = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    typedef enum logic [1:0] {
        ITEM_WRITE,
        ITEM_BYTE,
        ITEM_ERROR
    } item_kind_t;

    // One entry of the queue from the header parser to the bit decoder.
    typedef struct packed {
        item_kind_t                kind;
        logic [7:0]                data;
        logic [LEN_W-1:0]          len;
        logic [MAX_CODE_BITS-1:0]  code;
        logic [TABLE_AW-1:0]       idx;
    } q_item_t;

    typedef struct packed {
        logic [7:0]                sym;
        logic [LEN_W-1:0]          len;
        logic [MAX_CODE_BITS-1:0]  code;
    } tbl_word_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_in_run;
        logic       stream_done;
        logic       code_error;
    } result_t;
endpackage
`default_nettype wire

>>> sv/hsd_channels.sv
// Handshake interfaces for the input byte and result channels.
`default_nettype none
interface hsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface hsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_in_run;
    logic       stream_done;
    logic       code_error;
    modport source (output valid, output symbol, output last_in_run,
                    output stream_done, output code_error, input ready);
    modport sink (input valid, input symbol, input last_in_run,
                  input stream_done, input code_error, output ready);
endinterface
`default_nettype wire

>>> sv/hsd_fifo.sv
// Short queue between the header parser and the bit decoder.
`default_nettype none
module hsd_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire hsd_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output hsd_pkg::q_item_t      pop_item,
    output logic                  empty
);
    hsd_pkg::q_item_t                 store [hsd_pkg::QUEUE_DEPTH];
    logic [hsd_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [hsd_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [hsd_pkg::QUEUE_AW:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign full     = (count_reg == (hsd_pkg::QUEUE_AW+1)'(hsd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

>>> sv/hsd_front.sv
// Header parser: takes archive bytes and queues table writes and payload bytes.
`default_nettype none
module hsd_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    hsd_in_if.sink                           in_ch,
    output logic                             q_push,
    output hsd_pkg::q_item_t                 q_item,
    input  wire logic                        q_full,
    output logic [hsd_pkg::TOTAL_W-1:0]      symbol_total
);
    typedef enum logic [2:0] {
        PH_TOTAL,
        PH_COUNT,
        PH_SYM,
        PH_LEN,
        PH_CODE,
        PH_PAYLOAD,
        PH_STOP
    } phase_t;

    phase_t                               phase_reg, phase_next;
    logic [2:0]                           hdr_idx_reg, hdr_idx_next;
    logic [hsd_pkg::TOTAL_W-1:0]          total_reg, total_next;
    logic [hsd_pkg::COUNT_W-1:0]          expected_reg, expected_next;
    logic [hsd_pkg::COUNT_W-1:0]          loaded_reg, loaded_next;
    logic [7:0]                           psym_reg, psym_next;
    logic [hsd_pkg::LEN_W-1:0]            plen_reg, plen_next;
    logic [2:0]                           left_reg, left_next;
    logic [hsd_pkg::LEN_W-1:0]            got_reg, got_next;
    logic [hsd_pkg::MAX_CODE_BITS-1:0]    code_reg, code_next;
    logic                                 take;
    logic [7:0]                           b;
    logic [5:0]                           round_up;
    logic [hsd_pkg::COUNT_W-1:0]          loaded_inc;
    logic [hsd_pkg::MAX_CODE_BITS-1:0]    code_v;
    logic [hsd_pkg::LEN_W-1:0]            got_v;

    assign in_ch.ready  = !q_full;
    assign take         = in_ch.valid && !q_full;
    assign b            = in_ch.in_byte;
    assign symbol_total = total_reg;
    assign round_up     = {1'b0, b[4:0]} + 6'd7;
    assign loaded_inc   = loaded_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        total_next    = total_reg;
        expected_next = expected_reg;
        loaded_next   = loaded_reg;
        psym_next     = psym_reg;
        plen_next     = plen_reg;
        left_next     = left_reg;
        got_next      = got_reg;
        code_next     = code_reg;
        q_push        = 1'b0;
        q_item        = '0;
        q_item.kind   = hsd_pkg::ITEM_BYTE;
        q_item.data   = b;
        q_item.idx    = loaded_reg[hsd_pkg::TABLE_AW-1:0];
        code_v        = code_reg;
        got_v         = got_reg;
        // Only the first plen bits of the code bytes count; padding is dropped.
        for (int i = 7; i >= 0; i--)
        begin
            if (got_v < plen_reg)
            begin
                code_v = {code_v[hsd_pkg::MAX_CODE_BITS-2:0], b[i]};
                got_v  = got_v + 1'b1;
            end
        end
        if (take)
        begin
            unique case (phase_reg)
                PH_TOTAL:
                begin
                    total_next   = {total_reg[hsd_pkg::TOTAL_W-9:0], b};
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == 3'd7)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    expected_next = (b == 8'd0) ? hsd_pkg::COUNT_W'(hsd_pkg::TABLE_ENTRIES)
                                                : {1'b0, b};
                    loaded_next   = '0;
                    phase_next    = PH_SYM;
                end
                PH_SYM:
                begin
                    psym_next  = b;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (b > 8'(hsd_pkg::MAX_CODE_BITS))
                    begin
                        q_push      = 1'b1;
                        q_item.kind = hsd_pkg::ITEM_ERROR;
                        phase_next  = PH_STOP;
                    end
                    else
                    begin
                        plen_next = b[hsd_pkg::LEN_W-1:0];
                        left_next = round_up[5:3];
                        got_next  = '0;
                        code_next = '0;
                        if (b == 8'd0)
                        begin
                            // An empty code is stored but can never match.
                            q_push      = 1'b1;
                            q_item.kind = hsd_pkg::ITEM_WRITE;
                            q_item.data = psym_reg;
                            q_item.len  = '0;
                            q_item.code = '0;
                            loaded_next = loaded_inc;
                            if (loaded_inc >= expected_reg)
                            begin
                                phase_next = (total_reg == '0) ? PH_STOP : PH_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = PH_SYM;
                            end
                        end
                        else
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                end
                PH_CODE:
                begin
                    code_next = code_v;
                    got_next  = got_v;
                    left_next = left_reg - 1'b1;
                    if (left_reg == 3'd1)
                    begin
                        q_push      = 1'b1;
                        q_item.kind = hsd_pkg::ITEM_WRITE;
                        q_item.data = psym_reg;
                        q_item.len  = plen_reg;
                        q_item.code = code_v;
                        loaded_next = loaded_inc;
                        if (loaded_inc >= expected_reg)
                        begin
                            phase_next = (total_reg == '0) ? PH_STOP : PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = PH_SYM;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    q_push = 1'b1;
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TOTAL;
            hdr_idx_reg  <= '0;
            total_reg    <= '0;
            expected_reg <= '0;
            loaded_reg   <= '0;
            psym_reg     <= '0;
            plen_reg     <= '0;
            left_reg     <= '0;
            got_reg      <= '0;
            code_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            total_reg    <= total_next;
            expected_reg <= expected_next;
            loaded_reg   <= loaded_next;
            psym_reg     <= psym_next;
            plen_reg     <= plen_next;
            left_reg     <= left_next;
            got_reg      <= got_next;
            code_reg     <= code_next;
        end
    end
endmodule
`default_nettype wire

>>> sv/hsd_back.sv
// Bit decoder: holds the code table, matches payload bits and drives results.
`default_nettype none
`include "huffman_stream_decoder_assert.svh"
module hsd_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire hsd_pkg::q_item_t            q_item,
    output logic                             q_pop,
    input  wire logic [hsd_pkg::TOTAL_W-1:0] symbol_total,
    hsd_out_if.source                        out_ch
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_READ,
        ST_CMP,
        ST_RESOLVE,
        ST_FLUSH
    } state_t;

    hsd_pkg::tbl_word_t                   tbl [hsd_pkg::TABLE_ENTRIES];
    hsd_pkg::tbl_word_t                   rd_q;
    logic                                 wr_en;

    state_t                               st_reg, st_next;
    logic [7:0]                           byte_reg, byte_next;
    logic [2:0]                           bit_reg, bit_next;
    logic [hsd_pkg::MAX_CODE_BITS-1:0]    acc_reg, acc_next;
    logic [hsd_pkg::LEN_W-1:0]            cnt_reg, cnt_next;
    logic [hsd_pkg::TABLE_AW-1:0]         k_reg, k_next;
    logic                                 hit_reg, hit_next;
    logic [7:0]                           hsym_reg, hsym_next;
    logic [hsd_pkg::COUNT_W-1:0]          loaded_reg, loaded_next;
    logic [hsd_pkg::TOTAL_W-1:0]          dec_reg, dec_next;
    logic                                 stopped_reg, stopped_next;
    logic                                 held_valid_reg, held_valid_next;
    hsd_pkg::result_t                     held_reg, held_next;
    logic                                 out_valid_reg, out_valid_next;
    hsd_pkg::result_t                     out_reg, out_next;

    logic                                 out_free;
    logic                                 push;
    hsd_pkg::result_t                     push_res;
    hsd_pkg::result_t                     new_res;
    logic                                 want;
    logic                                 done;
    logic [hsd_pkg::TOTAL_W-1:0]          dec_inc;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign dec_inc  = dec_reg + 1'b1;
    assign done     = dec_inc >= symbol_total;
    assign want     = hit_reg || (cnt_reg == hsd_pkg::LEN_W'(hsd_pkg::MAX_CODE_BITS));

    always_comb
    begin
        new_res             = '0;
        new_res.symbol      = hit_reg ? hsym_reg : 8'd0;
        new_res.stream_done = hit_reg && done;
        new_res.code_error  = !hit_reg;
    end

    always_comb
    begin
        st_next         = st_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        hit_next        = hit_reg;
        hsym_next       = hsym_reg;
        loaded_next     = loaded_reg;
        dec_next        = dec_reg;
        stopped_next    = stopped_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        push            = 1'b0;
        push_res        = held_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (!stopped_reg)
                    begin
                        case (q_item.kind)
                            hsd_pkg::ITEM_WRITE:
                            begin
                                wr_en       = 1'b1;
                                loaded_next = loaded_reg + 1'b1;
                            end
                            hsd_pkg::ITEM_BYTE:
                            begin
                                byte_next = q_item.data;
                                bit_next  = '1;
                                st_next   = ST_BIT;
                            end
                            hsd_pkg::ITEM_ERROR:
                            begin
                                held_valid_next      = 1'b1;
                                held_next            = '0;
                                held_next.code_error = 1'b1;
                                stopped_next         = 1'b1;
                                st_next              = ST_FLUSH;
                            end
                            default:
                            begin
                                st_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_BIT:
            begin
                acc_next = {acc_reg[hsd_pkg::MAX_CODE_BITS-2:0], byte_reg[bit_reg]};
                cnt_next = cnt_reg + 1'b1;
                hit_next = 1'b0;
                if (loaded_reg == '0)
                begin
                    st_next = ST_RESOLVE;
                end
                else
                begin
                    // Scan from the newest entry so the last loaded duplicate wins.
                    k_next  = loaded_reg[hsd_pkg::TABLE_AW-1:0] - 1'b1;
                    st_next = ST_READ;
                end
            end
            ST_READ:
            begin
                st_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rd_q.len == cnt_reg && rd_q.code == acc_reg)
                begin
                    hit_next  = 1'b1;
                    hsym_next = rd_q.sym;
                    st_next   = ST_RESOLVE;
                end
                else if (k_reg == '0)
                begin
                    st_next = ST_RESOLVE;
                end
                else
                begin
                    k_next  = k_reg - 1'b1;
                    st_next = ST_READ;
                end
            end
            ST_RESOLVE:
            begin
                if (!(want && held_valid_reg && !out_free))
                begin
                    if (want)
                    begin
                        // The held result is not the last of this byte.
                        if (held_valid_reg)
                        begin
                            push                 = 1'b1;
                            push_res             = held_reg;
                            push_res.last_in_run = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_next       = new_res;
                    end
                    if (hit_reg)
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                        dec_next = dec_inc;
                    end
                    if (want && (!hit_reg || done))
                    begin
                        stopped_next = 1'b1;
                        st_next      = ST_FLUSH;
                    end
                    else if (bit_reg == '0)
                    begin
                        st_next = ST_FLUSH;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                        st_next  = ST_BIT;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!held_valid_reg)
                begin
                    st_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push                 = 1'b1;
                    push_res             = held_reg;
                    push_res.last_in_run = 1'b1;
                    held_valid_next      = 1'b0;
                    st_next              = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.symbol      = out_reg.symbol;
    assign out_ch.last_in_run = out_reg.last_in_run;
    assign out_ch.stream_done = out_reg.stream_done;
    assign out_ch.code_error  = out_reg.code_error;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl[q_item.idx] <= '{sym: q_item.data, len: q_item.len, code: q_item.code};
        end
        rd_q <= tbl[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            byte_reg       <= '0;
            bit_reg        <= '0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            hit_reg        <= 1'b0;
            hsym_reg       <= '0;
            loaded_reg     <= '0;
            dec_reg        <= '0;
            stopped_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            st_reg         <= st_next;
            byte_reg       <= byte_next;
            bit_reg        <= bit_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            hit_reg        <= hit_next;
            hsym_reg       <= hsym_next;
            loaded_reg     <= loaded_next;
            dec_reg        <= dec_next;
            stopped_reg    <= stopped_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    `HSD_ASSERT(a_stop_sticks, stopped_reg |=> stopped_reg)
    `HSD_ASSERT(a_cmp_after_read, st_reg == ST_CMP |-> $past(st_reg) == ST_READ)
    `HSD_NEVER(a_error_without_stop, held_valid_reg && held_reg.code_error && !stopped_reg)
    `HSD_NEVER(a_empty_acc, cnt_reg == '0 && acc_reg != '0)
endmodule
`default_nettype wire

>>> sv/huffman_stream_decoder.sv
// Top level of the Huffman stream decoder: header parser, queue and bit decoder.
//
//  Channel  Dir  Payload                                            Handshake
//  in_ch    in   in_byte[7:0]                                       valid/ready
//  out_ch   out  symbol[7:0], last_in_run, stream_done, code_error  valid/ready
//
// The parser takes a header byte whenever the queue is not full.
// A payload byte is decoded bit by bit in the decoder; for each bit it scans table entries
// from the newest back until a match (at most the number loaded), each one through the
// registered read of the table memory.
// Reset clears all control state; the code table holds garbage until loaded.
// Either side may stall: the queue and the output register decouple them.
`default_nettype none
module huffman_stream_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hsd_in_if.sink     in_ch,
    hsd_out_if.source  out_ch
);
    logic                              q_push;
    hsd_pkg::q_item_t                  q_push_item;
    logic                              q_full;
    logic                              q_pop;
    hsd_pkg::q_item_t                  q_pop_item;
    logic                              q_empty;
    logic [hsd_pkg::TOTAL_W-1:0]       symbol_total;

    hsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .q_push       (q_push),
        .q_item       (q_push_item),
        .q_full       (q_full),
        .symbol_total (symbol_total)
    );

    hsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    hsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (q_pop_item),
        .q_pop        (q_pop),
        .symbol_total (symbol_total),
        .out_ch       (out_ch)
    );
endmodule
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the Huffman stream decoder: one archive, checked per item.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    typedef enum logic [2:0] {
        DEC_TOTAL,
        DEC_COUNT,
        DEC_SYM,
        DEC_LEN,
        DEC_CODE,
        DEC_PAYLOAD,
        DEC_STOP
    } dec_phase_t;

    typedef struct {
        logic [7:0] in_byte;
        int         n_results;
    } header_row_t;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int PAYLOAD_BITS   = 8 * 110;
    localparam logic [30:0] LONG_CODE = 31'(32'hE5A5_5AC3 >> 1);
    localparam logic [7:0]  WIDE_CODE = 8'hD0;

    logic clk;
    logic rst_n;

    hsd_in_if  in_ch ();
    hsd_out_if out_ch ();

    huffman_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state.
    dec_phase_t        ph;
    int                hdr_idx;
    logic [63:0]       sym_total;
    int                n_entries;
    int                n_loaded;
    logic [7:0]        p_sym;
    int                p_len;
    int                bytes_left;
    logic [7:0]        tbl_sym [256];
    logic [4:0]        tbl_len [256];
    logic [30:0]       tbl_code [256];
    logic [30:0]       acc;
    int                acc_bits;
    logic [63:0]       n_decoded;

    hsd_pkg::result_t  expected_results[$];
    header_row_t       hdr_rows[$];
    logic              pay_bits[$];
    int                mismatches;
    int                src_idle;
    int                snk_idle;
    int                quiet_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void add_row(logic [7:0] b, int n);
        header_row_t row;
        row.in_byte   = b;
        row.n_results = n;
        hdr_rows.insert(hdr_rows.size(), row);
    endfunction

    function automatic void add_bit(logic v);
        pay_bits.insert(pay_bits.size(), v);
    endfunction

    function automatic void push_result(logic [7:0] s, logic done, logic err);
        hsd_pkg::result_t r;
        r.symbol      = s;
        r.last_in_run = 1'b0;
        r.stream_done = done;
        r.code_error  = err;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void entry_done();
        n_loaded++;
        if (n_loaded >= n_entries)
            ph = (sym_total == 64'd0) ? DEC_STOP : DEC_PAYLOAD;
        else
            ph = DEC_SYM;
    endfunction

    // Work out the results one archive byte causes and queue them.
    function automatic int decode_byte(logic [7:0] b);
        int   first;
        int   got;
        int   i;
        int   k;
        logic hit;
        logic [7:0] s;
        first = expected_results.size();
        case (ph)
            DEC_TOTAL:
            begin
                sym_total = {sym_total[55:0], b};
                hdr_idx++;
                if (hdr_idx >= 8)
                begin
                    hdr_idx = 0;
                    ph = DEC_COUNT;
                end
            end
            DEC_COUNT:
            begin
                n_entries = (b == 8'd0) ? hsd_pkg::TABLE_ENTRIES : int'(b);
                n_loaded = 0;
                ph = DEC_SYM;
            end
            DEC_SYM:
            begin
                p_sym = b;
                ph = DEC_LEN;
            end
            DEC_LEN:
            begin
                p_len = int'(b);
                if (p_len > hsd_pkg::MAX_CODE_BITS)
                begin
                    push_result(8'd0, 1'b0, 1'b1);
                    ph = DEC_STOP;
                end
                else
                begin
                    tbl_sym[n_loaded % 256] = p_sym;
                    tbl_len[n_loaded % 256] = b[4:0];
                    tbl_code[n_loaded % 256] = '0;
                    bytes_left = (p_len + 7) / 8;
                    if (bytes_left == 0)
                        entry_done();
                    else
                        ph = DEC_CODE;
                end
            end
            DEC_CODE:
            begin
                // Bits past the code length are padding and are dropped.
                got = ((p_len + 7) / 8 - bytes_left) * 8;
                for (i = 7; i >= 0; i--)
                begin
                    if (got < p_len)
                    begin
                        tbl_code[n_loaded % 256] = {tbl_code[n_loaded % 256][29:0], b[i]};
                        got++;
                    end
                end
                bytes_left--;
                if (bytes_left == 0)
                    entry_done();
            end
            DEC_PAYLOAD:
            begin
                for (i = 7; i >= 0 && ph == DEC_PAYLOAD; i--)
                begin
                    acc = {acc[29:0], b[i]};
                    acc_bits++;
                    hit = 1'b0;
                    s = 8'd0;
                    // The entry loaded last wins among duplicates.
                    for (k = n_loaded - 1; k >= 0 && !hit; k--)
                    begin
                        if (int'(tbl_len[k % 256]) == acc_bits && tbl_code[k % 256] == acc)
                        begin
                            hit = 1'b1;
                            s = tbl_sym[k % 256];
                        end
                    end
                    if (hit)
                    begin
                        acc = '0;
                        acc_bits = 0;
                        n_decoded++;
                        if (n_decoded >= sym_total)
                        begin
                            push_result(s, 1'b1, 1'b0);
                            ph = DEC_STOP;
                        end
                        else
                            push_result(s, 1'b0, 1'b0);
                    end
                    else if (acc_bits >= hsd_pkg::MAX_CODE_BITS)
                    begin
                        push_result(8'd0, 1'b0, 1'b1);
                        ph = DEC_STOP;
                    end
                end
            end
            default:
                ph = DEC_STOP;
        endcase
        if (expected_results.size() > first)
            expected_results[$].last_in_run = 1'b1;
        return expected_results.size() - first;
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", what);
    endfunction

    task automatic send_byte(logic [7:0] b, output int n_res);
        while ($urandom_range(0, 99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_res = decode_byte(b);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
                note_mismatch($sformatf("unexpected result symbol=%02h err=%b",
                                        out_ch.symbol, out_ch.code_error));
            else
            begin
                hsd_pkg::result_t e;
                e = expected_results.pop_front();
                if (out_ch.symbol !== e.symbol || out_ch.last_in_run !== e.last_in_run ||
                    out_ch.stream_done !== e.stream_done ||
                    out_ch.code_error !== e.code_error)
                    note_mismatch($sformatf(
                        "expected sym=%02h last=%b done=%b err=%b, got %02h %b %b %b",
                        e.symbol, e.last_in_run, e.stream_done, e.code_error,
                        out_ch.symbol, out_ch.last_in_run, out_ch.stream_done,
                        out_ch.code_error));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]  pay_byte;
        int          n_syms;
        int          pick;
        int          i;
        int          n_res;
        logic        end_in_error;
        logic [63:0] total_field;

        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'd0;
        out_ch.ready  = 1'b0;
        rst_n         = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        src_idle      = 20;
        snk_idle      = 75;
        ph            = DEC_TOTAL;
        hdr_idx       = 0;
        sym_total     = '0;
        n_entries     = 0;
        n_loaded      = 0;
        p_sym         = '0;
        p_len         = 0;
        bytes_left    = 0;
        acc           = '0;
        acc_bits      = 0;
        n_decoded     = '0;

        // Build the payload from table codes first so the symbol total is known.
        end_in_error = ($urandom_range(0, 3) == 0);
        n_syms = 0;
        while (pay_bits.size() < PAYLOAD_BITS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                for (i = 30; i >= 0; i--) add_bit(LONG_CODE[i]);
            end
            else if (pick <= 2)
            begin
                for (i = 7; i >= 0; i--) add_bit(WIDE_CODE[i]);
            end
            else if (pick <= 6)
            begin
                add_bit(1'b0);
                add_bit(1'b0);
            end
            else if (pick <= 10)
            begin
                add_bit(1'b0);
                add_bit(1'b1);
            end
            else if (pick <= 14)
            begin
                add_bit(1'b1);
                add_bit(1'b0);
                add_bit(1'b0);
            end
            else
            begin
                add_bit(1'b1);
                add_bit(1'b0);
                add_bit(1'b1);
            end
            n_syms++;
        end
        if (end_in_error)
        begin
            // No code starts with four ones, so 31 bits pass without a match.
            for (i = 0; i < 4; i++) add_bit(1'b1);
            for (i = 0; i < 27; i++) add_bit(1'($urandom_range(0, 1)));
        end
        while (pay_bits.size() % 8 != 0)
            add_bit(1'($urandom_range(0, 1)));
        total_field = end_in_error ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(n_syms);

        for (i = 7; i >= 0; i--)
            add_row(total_field[i*8 +: 8], 0);
        add_row(8'd8, 0);
        // Two-bit code with padding ones after it.
        add_row(8'h00, 0); add_row(8'd2, 0);
        add_row(8'h3F, 0);
        add_row(8'hFF, 0); add_row(8'd2, 0);
        add_row(8'h40, 0);
        // Zero length entry carries no code bytes and never matches.
        add_row(8'h41, 0); add_row(8'd0, 0);
        add_row(8'h5A, 0); add_row(8'd3, 0);
        add_row(8'h80, 0);
        add_row(8'h33, 0); add_row(8'd3, 0);
        add_row(8'hA0, 0);
        add_row(8'h77, 0); add_row(8'd31, 0);
        add_row(8'hE5, 0); add_row(8'hA5, 0);
        add_row(8'h5A, 0); add_row(8'hC3, 0);
        // Same code as the first entry; this later one must win.
        add_row(8'h99, 0); add_row(8'd2, 0);
        add_row(8'h00, 0);
        add_row(8'hC8, 0); add_row(8'd8, 0);
        add_row(8'hD0, 0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (hdr_rows[r])
        begin
            send_byte(hdr_rows[r].in_byte, n_res);
            if (n_res != hdr_rows[r].n_results)
                note_mismatch($sformatf("header item %0d: expected %0d results, got %0d",
                                        r, hdr_rows[r].n_results, n_res));
        end

        for (i = 0; i < pay_bits.size() / 8; i++)
        begin
            if (i == 40)
            begin
                src_idle = 75;
                snk_idle = 20;
            end
            else if (i == 80)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (i == 60)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
                while (expected_results.size() != 0)
                    @(negedge clk);
            end
            pay_byte = {pay_bits[i*8], pay_bits[i*8+1], pay_bits[i*8+2], pay_bits[i*8+3],
                        pay_bits[i*8+4], pay_bits[i*8+5], pay_bits[i*8+6], pay_bits[i*8+7]};
            send_byte(pay_byte, n_res);
        end

        // The decoder has stopped; these items must be ignored.
        for (i = 0; i < 4; i++)
            send_byte(8'($urandom_range(0, 255)), n_res);
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
